/* sv/mtpd_pkg.sv */
// Shared types and constants for the multichannel phase-angle dimmer.
`timescale 1ns / 1ps
`default_nettype none
package mtpd_pkg;

  localparam int OP_W    = 2;
  localparam int CHAN_W  = 3;
  localparam int DELAY_W = 10;
  localparam int MASK_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_ZERO     = 2'd1,
    OP_SET      = 2'd2,
    OP_ALL_OFF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FULL = 2'd1,
    MODE_DIM  = 2'd2
  } mode_t;

  typedef struct packed {
    logic               en;
    op_t                op;
    logic [DELAY_W-1:0] intensity;
    logic               set_on;
  } req_t;

  typedef struct packed {
    logic fire;
    logic gate;
    logic on;
  } chan_out_t;

endpackage
`default_nettype wire

/* sv/mtpd_channel.sv */
// One dimmer channel: mode, delay, countdown, gate level and on flag.
`timescale 1ns / 1ps
`default_nettype none
module mtpd_channel
  import mtpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      req,
  input  wire logic      sel,
  output chan_out_t      status
);

  mode_t              mode;
  mode_t              mode_next;
  logic [DELAY_W-1:0] cnt;
  logic [DELAY_W-1:0] cnt_next;
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] delay_next;
  logic               gate;
  logic               gate_next;
  logic               on;
  logic               on_next;
  logic               fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_OFF;
      cnt   <= '0;
      delay <= '0;
      gate  <= 1'b0;
      on    <= 1'b0;
    end else begin
      mode  <= mode_next;
      cnt   <= cnt_next;
      delay <= delay_next;
      gate  <= gate_next;
      on    <= on_next;
    end
  end

  always_comb begin
    mode_next  = mode;
    cnt_next   = cnt;
    delay_next = delay;
    gate_next  = gate;
    on_next    = on;
    fire       = 1'b0;
    if (req.en) begin
      case (req.op)
        OP_TICK: begin
          if (mode == MODE_DIM && cnt != '0) begin
            cnt_next = cnt - DELAY_W'(1);
            if (cnt == DELAY_W'(1)) begin
              fire      = 1'b1;
              gate_next = 1'b0;
            end
          end
        end
        OP_ZERO: begin
          if (mode == MODE_DIM) begin
            cnt_next = delay;
          end
        end
        OP_SET: begin
          if (sel) begin
            if (req.intensity == '0) begin
              on_next   = 1'b0;
              mode_next = MODE_OFF;
              gate_next = 1'b0;
            end else if (req.intensity == DELAY_W'(1)) begin
              if (req.set_on) begin
                on_next = 1'b1;
              end
              mode_next  = MODE_FULL;
              delay_next = '0;
              gate_next  = 1'b1;
            end else begin
              if (req.set_on) begin
                on_next = 1'b1;
              end
              mode_next  = MODE_DIM;
              delay_next = req.intensity;
              gate_next  = 1'b0;
            end
          end
        end
        OP_ALL_OFF: begin
          mode_next = MODE_OFF;
          gate_next = 1'b0;
          on_next   = 1'b0;
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  assign status.fire = fire;
  assign status.gate = gate_next;
  assign status.on   = on_next;

  a_full_gate_high: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_FULL) |-> gate)
    else $error("full-on channel with gate low");

  a_other_gate_low: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_FULL) |-> !gate)
    else $error("gate high outside full-on");

  a_fire_dimmed: assert property (@(posedge clk) disable iff (rst)
    fire |-> (mode == MODE_DIM && cnt == DELAY_W'(1)))
    else $error("gate pulse from a channel that is not counting out");

endmodule
`default_nettype wire

/* sv/multichannel_triac_phase_dimmer.sv */
// Top level of the multichannel phase-angle triac dimmer.
//
//   channel  dir  handshake            payload
//   request  in   in_valid / in_ready  operation, channel, intensity, set_on
//   result   out  out_valid/out_ready  fire_mask, gate_level_mask, on_mask
//
// One request a cycle while in_ready is high; its result is registered and
// shows the cycle after. All channel cells update in parallel from the
// request, and the output register holds their result masks.
// in_ready is high while the output register is empty or being taken.
// Reset clears every channel to off with zero delay and countdown.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_triac_phase_dimmer
  import mtpd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OP_W-1:0]    operation,
  input  wire logic [CHAN_W-1:0]  channel,
  input  wire logic [DELAY_W-1:0] intensity,
  input  wire logic               set_on,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [MASK_W-1:0]       fire_mask,
  output logic [MASK_W-1:0]       gate_level_mask,
  output logic [MASK_W-1:0]       on_mask
);

  logic                accept;
  req_t                req;
  chan_out_t           status [CHANNELS];
  logic [MASK_W-1:0]   fire_next;
  logic [MASK_W-1:0]   gate_next;
  logic [MASK_W-1:0]   on_next;

  assign in_ready      = !out_valid || out_ready;
  assign accept        = in_valid && in_ready;
  assign req.en        = accept;
  assign req.op        = op_t'(operation);
  assign req.intensity = intensity;
  assign req.set_on    = set_on;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    mtpd_channel u_chan (
      .clk    (clk),
      .rst    (rst),
      .req    (req),
      .sel    (int'(channel) == c),
      .status (status[c])
    );
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CHANNELS) begin : g_used
      assign fire_next[i] = status[i].fire;
      assign gate_next[i] = status[i].gate;
      assign on_next[i]   = status[i].on;
    end else begin : g_unused
      assign fire_next[i] = 1'b0;
      assign gate_next[i] = 1'b0;
      assign on_next[i]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fire_mask       <= fire_next;
      gate_level_mask <= gate_next;
      on_mask         <= on_next;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request left no result");

  a_fire_only_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && operation != OP_TICK) |=> (fire_mask == '0))
    else $error("gate pulse reported for a non-tick request");

  a_fire_gate_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((fire_mask & gate_level_mask) == '0))
    else $error("channel pulsed while its steady gate is high");

endmodule
`default_nettype wire
